>>> rtl/core/imm_pkg.sv
// Shared types, constants and helpers for the integer matrix multiplier.
`default_nettype none
package imm_pkg;

  localparam int MAX_DIM = 64;
  localparam int DIM_W = 6;
  localparam int ADDR_W = 2 * DIM_W;
  localparam int DEPTH = MAX_DIM * MAX_DIM;
  localparam int CFG_W = 7;
  localparam int WORD_W = 32;
  localparam int IN_DATA_W = 48;
  localparam int OUT_DATA_W = 48;

  typedef enum logic [1:0] {
    MODE_WR_A = 2'd0,
    MODE_WR_B = 2'd1,
    MODE_RD_C = 2'd2,
    MODE_NOP  = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    REG_ROWS_A    = 2'd0,
    REG_INNER_DIM = 2'd1,
    REG_COLS_B    = 2'd2,
    REG_NONE      = 2'd3
  } reg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic wr_a;
    logic wr_b;
    logic start;
    logic issue;
    logic load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic in_range;
    logic k_last;
    logic pipe_empty;
  } dp_stat_t;

  function automatic logic [CFG_W-1:0] clamp_dim(input logic [CFG_W-1:0] v);
    logic [CFG_W-1:0] res;
    res = v;
    if (v == '0) begin
      res = CFG_W'(1);
    end else if (v > CFG_W'(MAX_DIM)) begin
      res = CFG_W'(MAX_DIM);
    end
    return res;
  endfunction

endpackage
`default_nettype wire

>>> rtl/core/integer_matrix_multiply_top.sv
// Top level of the signed 32-bit integer matrix multiplier with stream ports.
// Write transfers of A or B elements (and unused mode 3) leave the controller idle and ready
// for the next input. A read of C inside the configured dimensions runs through RUN, one
// multiply-accumulate per cycle, and DRAIN before its result is loaded; a read outside C
// goes straight to DONE. No new input is taken until the read has loaded its result.
// A finished read waits while the previous result is still unaccepted; synchronous
// active-low reset sets all dimensions to 64 and empties the result register.
`default_nettype none
module integer_matrix_multiply_top
  import imm_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [IN_DATA_W-1:0]  in_tdata,  // row[5:0], col[11:6], value[43:12], zero pad
  input  wire logic [1:0]            in_tuser,  // mode[1:0]
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [OUT_DATA_W-1:0]      out_tdata, // product[31:0], out_row[37:32], out_col[43:38], zero pad
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [1:0]            cfg_index,
  input  wire logic [CFG_W-1:0]      cfg_data
);

  dp_cmd_t           cmd;
  dp_stat_t          stat;
  logic [WORD_W-1:0] product;
  logic [DIM_W-1:0]  res_row;
  logic [DIM_W-1:0]  res_col;

  assign cfg_ready = 1'b1;

  imm_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_mode    (mode_t'(in_tuser)),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .stat       (stat),
    .cmd        (cmd)
  );

  imm_datapath u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_valid),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_row      (in_tdata[DIM_W-1:0]),
    .in_col      (in_tdata[2*DIM_W-1:DIM_W]),
    .in_value    (in_tdata[2*DIM_W+WORD_W-1:2*DIM_W]),
    .cmd         (cmd),
    .stat        (stat),
    .out_product (product),
    .out_row     (res_row),
    .out_col     (res_col)
  );

  assign out_tdata = {{(OUT_DATA_W-WORD_W-2*DIM_W){1'b0}}, res_col, res_row, product};

endmodule
`default_nettype wire

>>> rtl/core/imm_datapath.sv
// Datapath: configuration registers, element stores, multiply-accumulate pipeline and result register.
`default_nettype none
module imm_datapath
  import imm_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [1:0]            cfg_index,
  input  wire logic [CFG_W-1:0]      cfg_data,
  input  wire logic [DIM_W-1:0]      in_row,
  input  wire logic [DIM_W-1:0]      in_col,
  input  wire logic [WORD_W-1:0]     in_value,
  input  wire dp_cmd_t               cmd,
  output dp_stat_t                   stat,
  output logic [WORD_W-1:0]          out_product,
  output logic [DIM_W-1:0]           out_row,
  output logic [DIM_W-1:0]           out_col
);

  logic [CFG_W-1:0]  rows_a_r;
  logic [CFG_W-1:0]  inner_dim_r;
  logic [CFG_W-1:0]  cols_b_r;
  logic [WORD_W-1:0] a_mem [DEPTH];
  logic [WORD_W-1:0] b_mem [DEPTH];
  logic [DIM_W-1:0]  row_r;
  logic [DIM_W-1:0]  col_r;
  logic [DIM_W-1:0]  k_r;
  logic [WORD_W-1:0] a_q_r;
  logic [WORD_W-1:0] b_q_r;
  logic              rd_v_r;
  logic [WORD_W-1:0] mul_r;
  logic              mul_v_r;
  logic [WORD_W-1:0] acc_r;
  logic [WORD_W-1:0] prod_r;
  logic [DIM_W-1:0]  orow_r;
  logic [DIM_W-1:0]  ocol_r;
  logic [WORD_W-1:0] mul_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_a_r    <= CFG_W'(MAX_DIM);
      inner_dim_r <= CFG_W'(MAX_DIM);
      cols_b_r    <= CFG_W'(MAX_DIM);
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_ROWS_A:    rows_a_r    <= clamp_dim(cfg_data);
        REG_INNER_DIM: inner_dim_r <= clamp_dim(cfg_data);
        REG_COLS_B:    cols_b_r    <= clamp_dim(cfg_data);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_a) begin
      a_mem[{in_row, in_col}] <= in_value;
    end
    if (cmd.issue) begin
      a_q_r <= a_mem[{row_r, k_r}];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_b) begin
      b_mem[{in_row, in_col}] <= in_value;
    end
    if (cmd.issue) begin
      b_q_r <= b_mem[{k_r, col_r}];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      row_r <= in_row;
      col_r <= in_col;
      k_r   <= '0;
    end else if (cmd.issue) begin
      k_r <= k_r + DIM_W'(1);
    end
  end

  assign mul_full = a_q_r * b_q_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_v_r  <= 1'b0;
      mul_v_r <= 1'b0;
    end else begin
      rd_v_r  <= cmd.issue;
      mul_v_r <= rd_v_r;
    end
  end

  always_ff @(posedge clk) begin
    mul_r <= mul_full;
    if (cmd.start) begin
      acc_r <= '0;
    end else if (mul_v_r) begin
      acc_r <= acc_r + mul_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      prod_r <= acc_r;
      orow_r <= row_r;
      ocol_r <= col_r;
    end
  end

  assign stat.in_range   = ({1'b0, in_row} < rows_a_r) && ({1'b0, in_col} < cols_b_r);
  assign stat.k_last     = ({1'b0, k_r} == (inner_dim_r - CFG_W'(1)));
  assign stat.pipe_empty = !rd_v_r && !mul_v_r;

  assign out_product = prod_r;
  assign out_row     = orow_r;
  assign out_col     = ocol_r;

endmodule
`default_nettype wire

>>> rtl/core/imm_ctrl.sv
// Controller state machine that sequences element writes and dot-product reads.
`default_nettype none
module imm_ctrl
  import imm_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  in_tvalid,
  input  wire mode_t in_mode,
  output logic       in_tready,
  output logic       out_tvalid,
  input  wire logic  out_tready,
  input  wire dp_stat_t stat,
  output dp_cmd_t    cmd
);

  state_t state_r;
  state_t state_nxt;
  logic   out_valid_r;
  logic   out_valid_nxt;
  logic   accept;
  logic   out_free;

  assign accept   = in_tvalid && (state_r == ST_IDLE);
  assign out_free = !out_valid_r || out_tready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept && (in_mode == MODE_RD_C)) begin
          state_nxt = stat.in_range ? ST_RUN : ST_DONE;
        end
      end
      ST_RUN: begin
        if (stat.k_last) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (stat.pipe_empty) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        cmd.wr_a  = accept && (in_mode == MODE_WR_A);
        cmd.wr_b  = accept && (in_mode == MODE_WR_B);
        cmd.start = accept && (in_mode == MODE_RD_C);
      end
      ST_RUN: begin
        cmd.issue = 1'b1;
      end
      ST_DONE: begin
        cmd.load_out = out_free;
      end
      default: ;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;

endmodule
`default_nettype wire

>>> rtl/core/imm_checker.sv
// Port-level checker for the integer matrix multiplier, bound to the top level.
`default_nettype none
module imm_checker
  import imm_pkg::*;
(
  input wire logic                  clk,
  input wire logic                  rst_n,
  input wire logic                  in_tvalid,
  input wire logic                  in_tready,
  input wire logic [1:0]            in_tuser,
  input wire logic                  out_tvalid,
  input wire logic                  out_tready,
  input wire logic [OUT_DATA_W-1:0] out_tdata
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed or dropped while stalled");

  a_read_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tuser == MODE_RD_C) |=> !in_tready)
    else $error("input taken while a read is in progress");

  a_result_from_read: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> !$past(in_tready))
    else $error("result raised while the block was idle");

endmodule

bind integer_matrix_multiply_top imm_checker u_imm_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
`default_nettype wire
